// ----- design/um32_pkg.sv -----
// Shared types, field positions and codes for the UM32 register execute unit.
package um32_pkg;

   // Register file geometry.
   localparam int REG_COUNT = 8;
   localparam int REG_IDX_W = $clog2(REG_COUNT);
   localparam int WORD_W    = 32;
   localparam int CHAR_W    = 8;

   // Instruction word fields.
   localparam int OPC_HI    = 31;
   localparam int OPC_LO    = 28;
   localparam int FLD_A_LO  = 6;
   localparam int FLD_B_LO  = 3;
   localparam int FLD_C_LO  = 0;
   localparam int FLD_LV_LO = 25;
   localparam int LV_IMM_W  = 25;

   // Iterative multiply and divide unit: one bit per cycle.
   localparam int MD_STEPS  = WORD_W;
   localparam int MD_CNT_W  = $clog2(MD_STEPS);

   // Stream payload widths.
   localparam int STAT_W      = 3;
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_FIELD_W = CHAR_W + REG_IDX_W + WORD_W + STAT_W;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic [3:0] {
      OP_CMOV      = 4'd0,
      OP_SEG_LOAD  = 4'd1,
      OP_SEG_STORE = 4'd2,
      OP_ADD       = 4'd3,
      OP_MUL       = 4'd4,
      OP_DIV       = 4'd5,
      OP_NAND      = 4'd6,
      OP_HALT      = 4'd7,
      OP_ALLOC     = 4'd8,
      OP_ABANDON   = 4'd9,
      OP_OUTPUT    = 4'd10,
      OP_INPUT     = 4'd11,
      OP_LOAD_PROG = 4'd12,
      OP_LOAD_VAL  = 4'd13
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 3'd0,
      STAT_HALT    = 3'd1,
      STAT_HALTED  = 3'd2,
      STAT_BADOP   = 3'd3,
      STAT_DIVZERO = 3'd4,
      STAT_OUTBIG  = 3'd5,
      STAT_SEGOP   = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ITER,
      ST_RESP
   } state_type;

   // Sequencer to multiply/divide unit.
   typedef struct packed {
      logic start;
      logic is_div;
   } md_req_type;

   // Multiply/divide unit back to sequencer.
   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] result;
   } md_rsp_type;

endpackage

// ----- design/um32_register_execute_unit.sv -----
// Top level of the UM32 register execute unit: sequencer, result register and assertions.
//
// Channel   Direction  Beat content
// req_*     in         tdata: instr_word[31:0], in_char[39:32]; tuser: in_eof
// rsp_*     out        tdata: out_char, dest_index, dest_value, status; tuser: out_valid,
//                      dest_written
//
// An instruction passes from accept through decode to the result beat; multiply and divide
// wait in between for the 32 one-bit steps of the shared multiply/divide unit and the
// registered hand-over of its result. The unit takes one instruction at a time:
// req_tready is high only when idle.
// Reset is synchronous and clears the registers (through per-entry valid bits), the halt
// flag and the sequencer. A stalled result beat holds until rsp_tready.
module um32_register_execute_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // instr_word[31:0], in_char[39:32]
   input  logic [um32_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // in_eof[0]
   input  logic [um32_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_char[7:0], dest_index[10:8], dest_value[42:11], status[45:43], zero[47:46]
   output logic [um32_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // out_valid[0], dest_written[1]
   output logic [um32_pkg::RSP_TUSER_W-1:0]    rsp_tuser
);
   import um32_pkg::*;

   state_type            state_ff, state_in;
   logic                 halted_ff, halted_in;
   logic [WORD_W-1:0]    word_ff;
   logic [CHAR_W-1:0]    char_ff;
   logic                 eof_ff;

   logic                 out_valid_ff;
   logic [CHAR_W-1:0]    out_char_ff;
   logic                 dest_written_ff;
   logic [REG_IDX_W-1:0] dest_index_ff;
   logic [WORD_W-1:0]    dest_value_ff;
   status_type           status_ff;

   logic                 req_accept;
   logic                 rsp_accept;
   logic                 load_rsp;
   logic                 r_ov;
   logic [CHAR_W-1:0]    r_oc;
   logic                 r_dw;
   logic [REG_IDX_W-1:0] r_di;
   logic [WORD_W-1:0]    r_dv;
   status_type           r_st;

   opcode_type           op;
   logic                 is_seg;
   logic [REG_IDX_W-1:0] ra, rc, ra_lv;
   logic [WORD_W-1:0]    vb, vc;
   md_req_type           md_req;
   md_rsp_type           md_rsp;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   // Decode of the held instruction word.
   assign op     = opcode_type'(word_ff[OPC_HI:OPC_LO]);
   assign ra     = word_ff[FLD_A_LO +: REG_IDX_W];
   assign rc     = word_ff[FLD_C_LO +: REG_IDX_W];
   assign ra_lv  = word_ff[FLD_LV_LO +: REG_IDX_W];
   assign is_seg = op inside {OP_SEG_LOAD, OP_SEG_STORE, OP_ALLOC, OP_ABANDON, OP_LOAD_PROG};

   um32_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_addr_b (req_tdata[FLD_B_LO +: REG_IDX_W]),
      .rd_addr_c (req_tdata[FLD_C_LO +: REG_IDX_W]),
      .rd_data_b (vb),
      .rd_data_c (vc),
      .wr_en     (load_rsp && r_dw),
      .wr_addr   (r_di),
      .wr_data   (r_dv)
   );

   um32_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .opnd_b (vb),
      .opnd_c (vc),
      .md_rsp (md_rsp)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = md_req.start ? ST_ITER : ST_RESP;
         end
         ST_ITER: begin
            if (md_rsp.done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_accept) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs and the result that is formed in each state.
   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      md_req.start  = 1'b0;
      md_req.is_div = 1'b0;
      load_rsp      = 1'b0;
      halted_in     = halted_ff;
      r_ov          = 1'b0;
      r_oc          = '0;
      r_dw          = 1'b0;
      r_di          = '0;
      r_dv          = '0;
      r_st          = STAT_OK;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_DECODE: begin
            load_rsp = 1'b1;
            if (halted_ff) begin
               r_st = STAT_HALTED;
            end else begin
               case (op)
                  OP_CMOV: begin
                     if (vc != '0) begin
                        r_dw = 1'b1;
                        r_di = ra;
                        r_dv = vb;
                     end
                  end
                  OP_ADD: begin
                     r_dw = 1'b1;
                     r_di = ra;
                     r_dv = vb + vc;
                  end
                  OP_MUL: begin
                     load_rsp     = 1'b0;
                     md_req.start = 1'b1;
                  end
                  OP_DIV: begin
                     if (vc == '0) begin
                        r_st = STAT_DIVZERO;
                     end else begin
                        load_rsp      = 1'b0;
                        md_req.start  = 1'b1;
                        md_req.is_div = 1'b1;
                     end
                  end
                  OP_NAND: begin
                     r_dw = 1'b1;
                     r_di = ra;
                     r_dv = ~(vb & vc);
                  end
                  OP_HALT: begin
                     r_st      = STAT_HALT;
                     halted_in = 1'b1;
                  end
                  OP_OUTPUT: begin
                     if (|vc[WORD_W-1:CHAR_W]) begin
                        r_st = STAT_OUTBIG;
                     end else begin
                        r_ov = 1'b1;
                        r_oc = vc[CHAR_W-1:0];
                     end
                  end
                  OP_INPUT: begin
                     r_dw = 1'b1;
                     r_di = rc;
                     r_dv = eof_ff ? '1 : {{(WORD_W-CHAR_W){1'b0}}, char_ff};
                  end
                  OP_LOAD_VAL: begin
                     r_dw = 1'b1;
                     r_di = ra_lv;
                     r_dv = {{(WORD_W-LV_IMM_W){1'b0}}, word_ff[LV_IMM_W-1:0]};
                  end
                  default: begin
                     r_st = is_seg ? STAT_SEGOP : STAT_BADOP;
                  end
               endcase
            end
         end
         ST_ITER: begin
            if (md_rsp.done) begin
               load_rsp = 1'b1;
               r_dw     = 1'b1;
               r_di     = ra;
               r_dv     = md_rsp.result;
            end
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         halted_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         halted_ff <= halted_in;
      end
   end

   // Accepted instruction beat.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         word_ff <= req_tdata[WORD_W-1:0];
         char_ff <= req_tdata[WORD_W +: CHAR_W];
         eof_ff  <= req_tuser[0];
      end
   end

   // Result register, held while the result beat is stalled.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         out_valid_ff    <= r_ov;
         out_char_ff     <= r_oc;
         dest_written_ff <= r_dw;
         dest_index_ff   <= r_di;
         dest_value_ff   <= r_dv;
         status_ff       <= r_st;
      end
   end

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, status_ff, dest_value_ff, dest_index_ff, out_char_ff};
   assign rsp_tuser = {dest_written_ff, out_valid_ff};

   // One instruction at a time: never ready while a result beat is offered.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result beat is pending");

   // The multiply/divide unit finishes only while the sequencer waits for it.
   a_md_done_in_iter: assert property (@(posedge clock) disable iff (reset)
      md_rsp.done |-> (state_ff == ST_ITER))
      else $error("multiply/divide finished outside its wait state");

   // Once halted, the unit stays halted until reset.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   // A beat reporting the halted state carries no register write and no byte.
   a_halted_no_effect: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (status_ff == STAT_HALTED)) |-> (!dest_written_ff && !out_valid_ff))
      else $error("halted unit reported a side effect");

endmodule

// ----- design/um32_regfile.sv -----
// Eight-entry register file with two registered read ports and valid bits for reset.
module um32_regfile (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [um32_pkg::REG_IDX_W-1:0] rd_addr_b,
   input  logic [um32_pkg::REG_IDX_W-1:0] rd_addr_c,
   output logic [um32_pkg::WORD_W-1:0]    rd_data_b,
   output logic [um32_pkg::WORD_W-1:0]    rd_data_c,
   input  logic                          wr_en,
   input  logic [um32_pkg::REG_IDX_W-1:0] wr_addr,
   input  logic [um32_pkg::WORD_W-1:0]    wr_data
);
   import um32_pkg::*;

   logic [WORD_W-1:0]    reg_mem_ff [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [WORD_W-1:0]    rd_b_ff;
   logic [WORD_W-1:0]    rd_c_ff;

   // Storage write; entries carry no reset.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         reg_mem_ff[wr_addr] <= wr_data;
      end
   end

   // An entry reads as zero until it has been written once after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Registered reads, taken only when an instruction is accepted.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_b_ff <= valid_ff[rd_addr_b] ? reg_mem_ff[rd_addr_b] : '0;
         rd_c_ff <= valid_ff[rd_addr_c] ? reg_mem_ff[rd_addr_c] : '0;
      end
   end

   assign rd_data_b = rd_b_ff;
   assign rd_data_c = rd_c_ff;

endmodule

// ----- design/um32_muldiv.sv -----
// Shared shift-add multiplier and restoring divider, one bit per cycle on one adder.
module um32_muldiv (
   input  logic                       clock,
   input  logic                       reset,
   input  um32_pkg::md_req_type       md_req,
   input  logic [um32_pkg::WORD_W-1:0] opnd_b,
   input  logic [um32_pkg::WORD_W-1:0] opnd_c,
   output um32_pkg::md_rsp_type       md_rsp
);
   import um32_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                is_div_ff, is_div_in;
   logic [MD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]   acc_ff, acc_in;
   logic [WORD_W-1:0]   quo_ff, quo_in;
   logic [WORD_W-1:0]   opnd_ff, opnd_in;
   logic [WORD_W:0]     add_a;
   logic [WORD_W:0]     add_b;
   logic [WORD_W:0]     sum;

   // The one adder: accumulate for multiply, trial subtract for divide.
   assign add_a = is_div_ff ? {acc_ff, quo_ff[WORD_W-1]} : {1'b0, acc_ff};
   assign add_b = {1'b0, opnd_ff};
   assign sum   = is_div_ff ? (add_a - add_b) : (add_a + add_b);

   // One step per cycle while busy; a start loads the operands.
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      is_div_in = is_div_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      quo_in    = quo_ff;
      opnd_in   = opnd_ff;
      if (md_req.start) begin
         busy_in   = 1'b1;
         is_div_in = md_req.is_div;
         cnt_in    = '0;
         acc_in    = '0;
         quo_in    = opnd_b;
         opnd_in   = opnd_c;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (is_div_ff) begin
            if (!sum[WORD_W]) begin
               acc_in = sum[WORD_W-1:0];
               quo_in = {quo_ff[WORD_W-2:0], 1'b1};
            end else begin
               acc_in = add_a[WORD_W-1:0];
               quo_in = {quo_ff[WORD_W-2:0], 1'b0};
            end
         end else begin
            if (quo_ff[0]) begin
               acc_in = sum[WORD_W-1:0];
            end
            quo_in  = {1'b0, quo_ff[WORD_W-1:1]};
            opnd_in = {opnd_ff[WORD_W-2:0], 1'b0};
         end
         if (cnt_ff == MD_CNT_W'(MD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      is_div_ff <= is_div_in;
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      quo_ff    <= quo_in;
      opnd_ff   <= opnd_in;
   end

   assign md_rsp.done   = done_ff;
   assign md_rsp.result = is_div_ff ? quo_ff : acc_ff;

endmodule
